>>> sv/dpf_pkg.sv
// shared types, constants, fixed-point helpers and the step program
`default_nettype none
package dpf_pkg;

  localparam int FRAC_BITS_DEF   = 48;
  localparam int COUNT_WIDTH_DEF = 32;

  typedef logic [63:0] word_t;

  typedef struct packed {
    logic [63:0] val;
    logic        ovf;
  } res_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } opc_t;

  typedef struct packed {
    opc_t       opc;
    logic [4:0] dst;
    logic [5:0] a;
    logic [5:0] b;
    logic       last;
  } op_t;

  // configuration register indexes
  localparam logic [2:0] CFG_STEP  = 3'd0;
  localparam logic [2:0] CFG_COEFF = 3'd1;
  localparam logic [2:0] CFG_INIT0 = 3'd2;

  localparam logic [48:0] STEP_RESET  = 49'd28147497671;
  localparam logic [62:0] COEFF_RESET = 63'd800542981262776730;
  localparam logic [63:0] INIT_RESET [6] = '{64'd562949953421312, 64'd0, 64'd0,
                                              64'd0, 64'd0, 64'd0};

  localparam logic [63:0] POS_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] NEG_MIN = {1'b1, {63{1'b0}}};

  // register file slots
  localparam int R_POS = 0;
  localparam int R_VEL = 3;
  localparam int R_PM  = 6;
  localparam int R_VM  = 9;
  localparam int R_ACC = 12;
  localparam int R_XX  = 15;
  localparam int R_YY  = 16;
  localparam int R_ZZ  = 17;
  localparam int R_R2  = 18;
  localparam int R_R   = 19;
  localparam int R_AMP = 20;
  localparam int R_PP  = 21;
  localparam int R_YZ  = 22;
  localparam int R_XZ  = 23;
  localparam int R_T0  = 24;
  localparam int R_T1  = 25;
  localparam int R_T2  = 26;
  localparam int R_T3  = 27;

  // operand sources beyond the register file
  localparam int S_ZERO = 32;
  localparam int S_H    = 33;
  localparam int S_HALF = 34;
  localparam int S_K    = 35;
  localparam int S_INIT = 36;

  localparam logic [6:0] PC_RESTART = 7'd0;
  localparam logic [6:0] PC_STEP    = 7'd6;

  function automatic logic [63:0] magn(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic res_t saturate(input logic neg, input logic [127:0] m);
    res_t r;
    logic [63:0] lim;
    lim = neg ? NEG_MIN : POS_MAX;
    if (m > {64'd0, lim}) begin
      r.val = lim;
      r.ovf = 1'b1;
    end else begin
      r.val = neg ? (64'd0 - m[63:0]) : m[63:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic res_t q_add(input logic [63:0] a, input logic [63:0] b);
    res_t r;
    logic [63:0] s;
    s = a + b;
    r.ovf = (a[63] == b[63]) && (s[63] != a[63]);
    r.val = r.ovf ? (a[63] ? NEG_MIN : POS_MAX) : s;
    return r;
  endfunction

  function automatic res_t q_sub(input logic [63:0] a, input logic [63:0] b);
    res_t r;
    logic [63:0] d;
    d = a - b;
    r.ovf = (a[63] != b[63]) && (d[63] != a[63]);
    r.val = r.ovf ? (a[63] ? NEG_MIN : POS_MAX) : d;
    return r;
  endfunction

  function automatic op_t mk(input opc_t opc, input int dst, input int a, input int b,
                             input logic last);
    op_t o;
    o.opc  = opc;
    o.dst  = 5'(dst);
    o.a    = 6'(a);
    o.b    = 6'(b);
    o.last = last;
    return o;
  endfunction

  // field acceleration at point pb with velocity vb into the acc slots
  function automatic op_t field_op(input int k, input int pb, input int vb);
    op_t o;
    case (k)
      0:  o = mk(OP_MUL, R_XX, pb, pb, 1'b0);
      1:  o = mk(OP_MUL, R_YY, pb + 1, pb + 1, 1'b0);
      2:  o = mk(OP_MUL, R_ZZ, pb + 2, pb + 2, 1'b0);
      3:  o = mk(OP_ADD, R_T0, R_XX, R_YY, 1'b0);
      4:  o = mk(OP_ADD, R_R2, R_T0, R_ZZ, 1'b0);
      5:  o = mk(OP_SQRT, R_R, R_R2, R_R2, 1'b0);
      6:  o = mk(OP_DIV, R_T0, S_K, R_R2, 1'b0);
      7:  o = mk(OP_DIV, R_T0, R_T0, R_R2, 1'b0);
      8:  o = mk(OP_DIV, R_AMP, R_T0, R_R, 1'b0);
      9:  o = mk(OP_ADD, R_T0, R_ZZ, R_ZZ, 1'b0);
      10: o = mk(OP_SUB, R_T0, R_T0, R_XX, 1'b0);
      11: o = mk(OP_SUB, R_PP, R_T0, R_YY, 1'b0);
      12: o = mk(OP_MUL, R_YZ, pb + 1, pb + 2, 1'b0);
      13: o = mk(OP_MUL, R_XZ, pb, pb + 2, 1'b0);
      14: o = mk(OP_MUL, R_T0, vb + 1, R_PP, 1'b0);
      15: o = mk(OP_MUL, R_T1, vb + 2, R_YZ, 1'b0);
      16: o = mk(OP_ADD, R_T2, R_T1, R_T1, 1'b0);
      17: o = mk(OP_ADD, R_T1, R_T2, R_T1, 1'b0);
      18: o = mk(OP_SUB, R_T0, R_T0, R_T1, 1'b0);
      19: o = mk(OP_MUL, R_T1, vb, R_PP, 1'b0);
      20: o = mk(OP_MUL, R_T2, vb + 2, R_XZ, 1'b0);
      21: o = mk(OP_ADD, R_T3, R_T2, R_T2, 1'b0);
      22: o = mk(OP_ADD, R_T2, R_T3, R_T2, 1'b0);
      23: o = mk(OP_SUB, R_T1, R_T1, R_T2, 1'b0);
      24: o = mk(OP_MUL, R_T2, vb, R_YZ, 1'b0);
      25: o = mk(OP_MUL, R_T3, vb + 1, R_XZ, 1'b0);
      26: o = mk(OP_SUB, R_T2, R_T2, R_T3, 1'b0);
      27: o = mk(OP_ADD, R_T3, R_T2, R_T2, 1'b0);
      28: o = mk(OP_ADD, R_T2, R_T3, R_T2, 1'b0);
      29: o = mk(OP_MUL, R_T3, R_AMP, R_T0, 1'b0);
      30: o = mk(OP_SUB, R_ACC, S_ZERO, R_T3, 1'b0);
      31: o = mk(OP_MUL, R_ACC + 1, R_AMP, R_T1, 1'b0);
      32: o = mk(OP_MUL, R_T3, R_AMP, R_T2, 1'b0);
      default: o = mk(OP_SUB, R_ACC + 2, S_ZERO, R_T3, 1'b0);
    endcase
    return o;
  endfunction

  // midpoint update (second = 0) or full update (second = 1)
  function automatic op_t upd_op(input int s, input logic second, input logic last);
    op_t o;
    int i;
    int hs;
    i  = s / 4;
    hs = second ? S_H : S_HALF;
    case (s % 4)
      0: o = mk(OP_MUL, R_T0, hs, R_ACC + i, 1'b0);
      1: o = mk(OP_ADD, second ? R_VEL + i : R_VM + i, R_VEL + i, R_T0, 1'b0);
      2: o = mk(OP_MUL, R_T0, hs, second ? R_VM + i : R_VEL + i, 1'b0);
      default: o = mk(OP_ADD, second ? R_POS + i : R_PM + i, R_POS + i, R_T0, last);
    endcase
    return o;
  endfunction

  function automatic op_t prog(input logic [6:0] pc);
    int p;
    op_t o;
    p = int'(pc);
    if (p < 6) begin
      o = mk(OP_ADD, R_POS + p, S_INIT + p, S_ZERO, p == 5);
    end else if (p < 40) begin
      o = field_op(p - 6, R_POS, R_VEL);
    end else if (p < 52) begin
      o = upd_op(p - 40, 1'b0, 1'b0);
    end else if (p < 86) begin
      o = field_op(p - 52, R_PM, R_VM);
    end else begin
      o = upd_op(p - 86, 1'b1, p == 97);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> sv/dpf_mul.sv
// fixed-point multiplier, four 32x32 partial products then shift and saturate
`default_nettype none
module dpf_mul #(
  parameter int FRAC_BITS = dpf_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic              done,
  output dpf_pkg::res_t     res
);

  logic [63:0]  am;
  logic [63:0]  bm;
  logic         neg;
  logic [127:0] acc;
  logic [2:0]   cnt;
  logic         busy;
  logic [63:0]  pp;
  logic [6:0]   sh;

  always_comb begin
    pp = am[{cnt[0], 5'b0} +: 32] * bm[{cnt[1], 5'b0} +: 32];
    sh = {cnt[0] & cnt[1], cnt[0] ^ cnt[1], 5'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        am   <= dpf_pkg::magn(a);
        bm   <= dpf_pkg::magn(b);
        neg  <= a[63] ^ b[63];
        acc  <= 128'd0;
        cnt  <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          acc <= acc + ({64'd0, pp} << sh);
          cnt <= cnt + 3'd1;
        end else begin
          res  <= dpf_pkg::saturate(neg, acc >> FRAC_BITS);
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/dpf_div.sv
// restoring divider, one quotient bit per cycle, saturating
`default_nettype none
module dpf_div #(
  parameter int FRAC_BITS = dpf_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic              done,
  output dpf_pkg::res_t     res
);

  localparam int N  = 64 + FRAC_BITS;
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  num;
  logic [N-1:0]  q;
  logic [63:0]   d;
  logic [63:0]   rem;
  logic          neg;
  logic          zero;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [64:0]   rem_sh;
  logic [64:0]   diff;
  logic          ge;

  always_comb begin
    rem_sh = {rem, num[N-1]};
    diff   = rem_sh - {1'b0, d};
    ge     = rem_sh >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num  <= {dpf_pkg::magn(a), {FRAC_BITS{1'b0}}};
        d    <= dpf_pkg::magn(b);
        q    <= '0;
        rem  <= 64'd0;
        neg  <= a[63] ^ b[63];
        zero <= (b == 64'd0);
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (zero) begin
          res.val <= neg ? dpf_pkg::NEG_MIN : dpf_pkg::POS_MAX;
          res.ovf <= 1'b1;
          done    <= 1'b1;
          busy    <= 1'b0;
        end else if (cnt != CW'(N)) begin
          rem <= ge ? diff[63:0] : rem_sh[63:0];
          q   <= {q[N-2:0], ge};
          num <= {num[N-2:0], 1'b0};
          cnt <= cnt + 1'b1;
        end else begin
          res  <= dpf_pkg::saturate(neg, 128'(q));
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/dpf_sqrt.sv
// digit-by-digit square root of the operand scaled up by the fraction bits
`default_nettype none
module dpf_sqrt #(
  parameter int FRAC_BITS = dpf_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [63:0]  a,
  output logic              done,
  output dpf_pkg::res_t     res
);

  localparam int W  = 64 + FRAC_BITS;
  localparam int W2 = W + (W % 2);
  localparam int IT = W2 / 2;
  localparam int CW = $clog2(IT + 1);

  logic [W2-1:0] rad;
  logic [IT:0]   rem;
  logic [IT-1:0] root;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [IT+2:0] rem_sh;
  logic [IT+2:0] trial;
  logic [IT+2:0] diff;
  logic          ge;

  always_comb begin
    rem_sh = {rem, rad[W2-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    diff   = rem_sh - trial;
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= W2'({a, {FRAC_BITS{1'b0}}});
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt != CW'(IT)) begin
          rem  <= ge ? diff[IT:0] : rem_sh[IT:0];
          root <= {root[IT-2:0], ge};
          rad  <= {rad[W2-3:0], 2'b00};
          cnt  <= cnt + 1'b1;
        end else begin
          res.val <= 64'(root);
          res.ovf <= 1'b0;
          done    <= 1'b1;
          busy    <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/dipole_field_particle_rk2_step.sv
// dipole field particle stepper: sequencer, register file and shared units
// a step item's time from accept to result is set by six serial divides, two square roots
// and 40 multiplies; one item at a time; the next item is taken while a result still waits
// reset loads the initial registers into the state, with no result
`default_nettype none
module dipole_field_particle_rk2_step #(
  parameter int FRAC_BITS   = dpf_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = dpf_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        restart,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      step_count,
  output logic [63:0]      pos_x,
  output logic [63:0]      pos_y,
  output logic [63:0]      pos_z,
  output logic [63:0]      vel_x,
  output logic [63:0]      vel_y,
  output logic [63:0]      vel_z,
  output logic             range_error
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_WAIT,
    ST_FINISH
  } state_t;

  state_t                 state;
  dpf_pkg::op_t           op;
  logic [6:0]             pc;
  logic                   boot;
  logic                   flag;
  logic [COUNT_WIDTH-1:0] count;
  logic [48:0]            step_size;
  logic [62:0]            field_coeff;
  logic [63:0]            init_val [6];
  logic [63:0]            mem [32];
  logic [63:0]            rd_a;
  logic [63:0]            rd_b;
  logic [63:0]            st [6];
  logic [63:0]            st_out [6];
  logic [63:0]            opa;
  logic [63:0]            opb;
  dpf_pkg::op_t           op_f;
  dpf_pkg::res_t          add_r;
  dpf_pkg::res_t          sub_r;
  dpf_pkg::res_t          mul_r;
  dpf_pkg::res_t          div_r;
  dpf_pkg::res_t          sqrt_r;
  dpf_pkg::res_t          wb;
  logic                   mul_done;
  logic                   div_done;
  logic                   sqrt_done;
  logic                   unit_done;
  logic                   is_alu;
  logic                   wb_en;
  logic                   mul_start;
  logic                   div_start;
  logic                   sqrt_start;

  function automatic logic [63:0] src_val(input logic [5:0] s, input logic [63:0] rd);
    logic [63:0] v;
    case (int'(s))
      dpf_pkg::S_ZERO:     v = 64'd0;
      dpf_pkg::S_H:        v = 64'(step_size);
      dpf_pkg::S_HALF:     v = 64'(step_size >> 1);
      dpf_pkg::S_K:        v = 64'(field_coeff);
      dpf_pkg::S_INIT:     v = init_val[0];
      dpf_pkg::S_INIT + 1: v = init_val[1];
      dpf_pkg::S_INIT + 2: v = init_val[2];
      dpf_pkg::S_INIT + 3: v = init_val[3];
      dpf_pkg::S_INIT + 4: v = init_val[4];
      dpf_pkg::S_INIT + 5: v = init_val[5];
      default:             v = rd;
    endcase
    return v;
  endfunction

  always_comb begin
    op_f       = dpf_pkg::prog(pc);
    opa        = src_val(op.a, rd_a);
    opb        = src_val(op.b, rd_b);
    add_r      = dpf_pkg::q_add(opa, opb);
    sub_r      = dpf_pkg::q_sub(opa, opb);
    is_alu     = (op.opc == dpf_pkg::OP_ADD) || (op.opc == dpf_pkg::OP_SUB);
    unit_done  = mul_done | div_done | sqrt_done;
    mul_start  = (state == ST_EXEC) && (op.opc == dpf_pkg::OP_MUL);
    div_start  = (state == ST_EXEC) && (op.opc == dpf_pkg::OP_DIV);
    sqrt_start = (state == ST_EXEC) && (op.opc == dpf_pkg::OP_SQRT);
    wb_en      = ((state == ST_EXEC) && is_alu) || ((state == ST_WAIT) && unit_done);
    if (state == ST_EXEC) begin
      wb = (op.opc == dpf_pkg::OP_ADD) ? add_r : sub_r;
    end else if (mul_done) begin
      wb = mul_r;
    end else if (div_done) begin
      wb = div_r;
    end else begin
      wb = sqrt_r;
    end
    in_stall = (state != ST_IDLE);
  end

  dpf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(opa), .b(opb),
    .done(mul_done), .res(mul_r)
  );

  dpf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(opa), .b(opb),
    .done(div_done), .res(div_r)
  );

  dpf_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .a(opa),
    .done(sqrt_done), .res(sqrt_r)
  );

  // register file
  always_ff @(posedge clk) begin
    if (wb_en) begin
      mem[op.dst] <= wb.val;
    end
    if (state == ST_FETCH) begin
      rd_a <= mem[op_f.a[4:0]];
      rd_b <= mem[op_f.b[4:0]];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size   <= dpf_pkg::STEP_RESET;
      field_coeff <= dpf_pkg::COEFF_RESET;
      init_val    <= dpf_pkg::INIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dpf_pkg::CFG_STEP:  step_size   <= cfg_data[48:0];
        dpf_pkg::CFG_COEFF: field_coeff <= cfg_data[62:0];
        default:            init_val[cfg_index - dpf_pkg::CFG_INIT0] <= cfg_data;
      endcase
    end
  end

  assign pos_x = st_out[0];
  assign pos_y = st_out[1];
  assign pos_z = st_out[2];
  assign vel_x = st_out[3];
  assign vel_y = st_out[4];
  assign vel_z = st_out[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FETCH;
      pc        <= dpf_pkg::PC_RESTART;
      boot      <= 1'b1;
      flag      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && ((state != ST_FINISH) || boot)) begin
        out_valid <= 1'b0;
      end
      if (wb_en && (op.dst < 5'd6)) begin
        st[op.dst[2:0]] <= wb.val;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            flag <= 1'b0;
            if (restart) begin
              pc    <= dpf_pkg::PC_RESTART;
              count <= '0;
            end else begin
              pc    <= dpf_pkg::PC_STEP;
              count <= count + 1'b1;
            end
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          op    <= op_f;
          state <= ST_EXEC;
        end
        ST_EXEC, ST_WAIT: begin
          if (wb_en) begin
            flag <= flag | wb.ovf;
            if (op.last) begin
              state <= ST_FINISH;
            end else begin
              pc    <= pc + 7'd1;
              state <= ST_FETCH;
            end
          end else if (state == ST_EXEC) begin
            state <= ST_WAIT;
          end
        end
        ST_FINISH: begin
          if (boot) begin
            boot  <= 1'b0;
            state <= ST_IDLE;
          end else if (!out_valid || !out_stall) begin
            st_out      <= st;
            step_count  <= 32'(count);
            range_error <= flag;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sim/dipole_field_particle_rk2_step_tb.sv
// testbench for the dipole field particle stepper: self-checking against an internal predictor
`default_nettype none
module dipole_field_particle_rk2_step_tb;

  localparam logic [63:0] MAX_POS = {1'b0, {63{1'b1}}};
  localparam logic [63:0] MIN_NEG = {1'b1, {63{1'b0}}};
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct {
    logic [31:0] step_count;
    logic [63:0] pos [3];
    logic [63:0] vel [3];
    logic        range_error;
  } state_beat_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        restart;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] step_count;
  logic [63:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
  logic        range_error;

  dipole_field_particle_rk2_step dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall), .step_count(step_count),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .vel_x(vel_x), .vel_y(vel_y),
    .vel_z(vel_z), .range_error(range_error)
  );

  // predictor copy of registers and particle state
  logic [48:0] h_step;
  logic [62:0] k_coeff;
  logic [63:0] init_val [6];
  logic [63:0] cur_pos [3];
  logic [63:0] cur_vel [3];
  logic [31:0] steps;
  logic        sat_seen;

  state_beat_t expected_beats [$];
  int          fail_count;
  int          burst_left;
  int          idle_cycles;
  int          stall_mode;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] abs64(input logic [63:0] a);
    return a[63] ? 64'd0 - a : a;
  endfunction

  function automatic logic [63:0] clamp(input logic neg, input logic [127:0] m);
    logic [63:0] lim;
    lim = neg ? MIN_NEG : MAX_POS;
    if (m > {64'd0, lim}) begin
      sat_seen = 1'b1;
      return lim;
    end
    return neg ? 64'd0 - m[63:0] : m[63:0];
  endfunction

  function automatic logic [63:0] fx_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_seen = 1'b1;
      return a[63] ? MIN_NEG : MAX_POS;
    end
    return s;
  endfunction

  function automatic logic [63:0] fx_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    if (a[63] != b[63] && d[63] != a[63]) begin
      sat_seen = 1'b1;
      return a[63] ? MIN_NEG : MAX_POS;
    end
    return d;
  endfunction

  function automatic logic [63:0] fx_triple(input logic [63:0] a);
    return fx_add(fx_add(a, a), a);
  endfunction

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    return clamp(a[63] != b[63], p >> 48);
  endfunction

  function automatic logic [63:0] fx_div(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] q;
    if (b == 64'd0) begin
      sat_seen = 1'b1;
      return a[63] ? MIN_NEG : MAX_POS;
    end
    q = ({64'd0, abs64(a)} << 48) / {64'd0, abs64(b)};
    return clamp(a[63] != b[63], q);
  endfunction

  function automatic logic [63:0] fx_root(input logic [63:0] a);
    logic [127:0] target;
    logic [63:0]  res;
    logic [63:0]  cand;
    target = {64'd0, a} << 48;
    res = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      if ({64'd0, cand} * {64'd0, cand} <= target) res = cand;
    end
    return res;
  endfunction

  function automatic void dipole_accel(input logic [63:0] p [3], input logic [63:0] v [3],
                                       output logic [63:0] acc [3]);
    logic [63:0] xx, yy, zz, r2, r, amp, pp, yz, xz, tx, ty, tz;
    xx = fx_mul(p[0], p[0]);
    yy = fx_mul(p[1], p[1]);
    zz = fx_mul(p[2], p[2]);
    r2 = fx_add(fx_add(xx, yy), zz);
    r = fx_root(r2);
    amp = fx_div(fx_div(fx_div({1'b0, k_coeff}, r2), r2), r);
    pp = fx_sub(fx_sub(fx_add(zz, zz), xx), yy);
    yz = fx_mul(p[1], p[2]);
    xz = fx_mul(p[0], p[2]);
    tx = fx_sub(fx_mul(v[1], pp), fx_triple(fx_mul(v[2], yz)));
    ty = fx_sub(fx_mul(v[0], pp), fx_triple(fx_mul(v[2], xz)));
    tz = fx_triple(fx_sub(fx_mul(v[0], yz), fx_mul(v[1], xz)));
    acc[0] = fx_sub(64'd0, fx_mul(amp, tx));
    acc[1] = fx_mul(amp, ty);
    acc[2] = fx_sub(64'd0, fx_mul(amp, tz));
  endfunction

  function automatic void advance_particle(input logic do_restart);
    logic [63:0] half, a1 [3], a2 [3], pm [3], vm [3];
    state_beat_t b;
    sat_seen = 1'b0;
    if (do_restart) begin
      for (int i = 0; i < 3; i++) begin
        cur_pos[i] = init_val[i];
        cur_vel[i] = init_val[3 + i];
      end
      steps = 32'd0;
    end else begin
      half = {15'd0, h_step >> 1};
      dipole_accel(cur_pos, cur_vel, a1);
      for (int i = 0; i < 3; i++) begin
        vm[i] = fx_add(cur_vel[i], fx_mul(half, a1[i]));
        pm[i] = fx_add(cur_pos[i], fx_mul(half, cur_vel[i]));
      end
      dipole_accel(pm, vm, a2);
      for (int i = 0; i < 3; i++) begin
        cur_vel[i] = fx_add(cur_vel[i], fx_mul({15'd0, h_step}, a2[i]));
        cur_pos[i] = fx_add(cur_pos[i], fx_mul({15'd0, h_step}, vm[i]));
      end
      steps = steps + 32'd1;
    end
    b.step_count = steps;
    b.pos = cur_pos;
    b.vel = cur_vel;
    b.range_error = sat_seen;
    expected_beats.push_back(b);
  endfunction

  // receiver stall pattern: phases of no stall, light and heavy stall
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // sampled at the falling edge; the beat moves on the next rising edge
  always @(negedge clk) begin
    state_beat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        e = expected_beats.pop_front();
        check_field("step_count", {32'd0, e.step_count}, {32'd0, step_count});
        check_field("pos_x", e.pos[0], pos_x);
        check_field("pos_y", e.pos[1], pos_y);
        check_field("pos_z", e.pos[2], pos_z);
        check_field("vel_x", e.vel[0], vel_x);
        check_field("vel_y", e.vel[1], vel_y);
        check_field("vel_z", e.vel[2], vel_z);
        check_field("range_error", {63'd0, e.range_error}, {63'd0, range_error});
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input logic r);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
    end
    burst_left--;
    in_valid <= 1'b1;
    restart <= r;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    advance_particle(r);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == dpf_pkg::CFG_STEP) h_step = data[48:0];
    else if (idx == dpf_pkg::CFG_COEFF) k_coeff = data[62:0];
    else init_val[idx - dpf_pkg::CFG_INIT0] = data;
  endtask

  task automatic load_setup(input logic [48:0] h, input logic [62:0] k,
                            input logic [63:0] p [3], input logic [63:0] v [3]);
    wait_idle();
    write_reg(dpf_pkg::CFG_STEP, {15'd0, h});
    write_reg(dpf_pkg::CFG_COEFF, {1'b0, k});
    for (int i = 0; i < 3; i++) begin
      write_reg(dpf_pkg::CFG_INIT0 + 3'(i), p[i]);
      write_reg(dpf_pkg::CFG_INIT0 + 3'(3 + i), v[i]);
    end
    cfg_write <= 1'b0;
    send_item(1'b1);
  endtask

  task automatic test_reset_state();
    repeat (3) send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  task automatic test_directed_cases();
    logic [63:0] p [3];
    logic [63:0] v [3];
    // radius zero
    p = '{64'd0, 64'd0, 64'd0};
    v = '{64'd1 << 40, 64'd0, 64'd0};
    load_setup(49'd28147497671, 63'd800542981262776730, p, v);
    repeat (2) send_item(1'b0);
    // zero step size
    p = '{64'd3 << 48, 64'd1 << 47, 64'd1 << 48};
    v = '{64'd1 << 36, 64'd0 - (64'd1 << 37), 64'd1 << 35};
    load_setup(49'd0, 63'd800542981262776730, p, v);
    repeat (2) send_item(1'b0);
    // unit step, largest coefficient, extreme state
    p = '{MAX_POS, MIN_NEG, MAX_POS};
    v = '{MIN_NEG, MAX_POS, MIN_NEG};
    load_setup({1'b1, 48'd0}, {63{1'b1}}, p, v);
    repeat (3) send_item(1'b0);
    // tiny radius with all ones in the low bits
    p = '{64'd1, 64'd0 - 64'd1, 64'd0};
    v = '{{64{1'b1}}, 64'd1, 64'hffff};
    load_setup(49'd1, 63'd0, p, v);
    repeat (2) send_item(1'b0);
    send_item(1'b1);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_coord(input int whole);
    logic [63:0] m;
    m = {32'd0, $urandom()} << 16;
    m = m + ({32'd0, 32'($urandom_range(0, whole))} << 48);
    return $urandom_range(0, 1) ? 64'd0 - m : m;
  endfunction

  task automatic test_random_orbits();
    logic [63:0] p [3];
    logic [63:0] v [3];
    logic [48:0] h;
    logic [62:0] k;
    int sent;
    sent = 0;
    while (sent < 1200) begin
      if ($urandom_range(0, 4) == 0) begin
        // wild setting, mostly saturating
        h = 49'({$urandom(), $urandom()});
        k = 63'({$urandom(), $urandom()});
        for (int i = 0; i < 3; i++) begin
          p[i] = rand_word();
          v[i] = rand_word();
        end
      end else begin
        h = 49'($urandom_range(1, 1 << 20)) << $urandom_range(0, 20);
        k = 63'({$urandom(), $urandom()}) >> $urandom_range(1, 40);
        for (int i = 0; i < 3; i++) begin
          p[i] = rand_coord(7);
          v[i] = rand_coord(0) >>> $urandom_range(0, 12);
        end
      end
      load_setup(h, k, p, v);
      sent++;
      repeat ($urandom_range(10, 40)) begin
        send_item($urandom_range(0, 15) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = dpf_pkg::CFG_STEP;
    cfg_data = 64'd0;
    in_valid = 1'b0;
    restart = 1'b0;
    out_stall = 1'b0;
    stall_mode = 0;
    fail_count = 0;
    burst_left = 0;
    idle_cycles = 0;
    h_step = 49'd28147497671;
    k_coeff = 63'd800542981262776730;
    init_val = '{64'd562949953421312, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
    for (int i = 0; i < 3; i++) begin
      cur_pos[i] = init_val[i];
      cur_vel[i] = init_val[3 + i];
    end
    steps = 32'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed_cases();
    test_random_orbits();
    wait_idle();
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
